// ----- design/bfdh_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants and types for the double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    localparam int unsigned DEFAULT_MAX_BITS = 65536;
    localparam int unsigned MIN_BITS         = 64;
    localparam int unsigned MAX_PROBES       = 20;
    localparam int unsigned CFG_IDX_W        = 1;
    localparam int unsigned CFG_DATA_W       = 17;
    localparam int unsigned BITS_W           = 17;
    localparam int unsigned PROBE_W          = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 1'b1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [63:0] SEED_A = 64'hcbf29ce484222325;
    localparam logic [63:0] MUL_A  = 64'h00000100000001b3;
    localparam logic [63:0] SEED_B = 64'h517cc1b727220a95;
    localparam logic [63:0] MUL_B  = 64'h2545f4914f6cdd1d;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic was_query;
        logic maybe_present;
    } out_item_t;

    // A finished key handed from the hashing front to the probing back.
    typedef struct packed {
        logic        opcode;
        logic [63:0] hash_a;
        logic [63:0] hash_b;
    } key_job_t;

endpackage

// ----- design/bfdh_if.sv -----
// ----------------------------------------------------------------------------
// Bloom filter channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bfdh_in_if;
    logic               valid;
    logic               ready;
    bfdh_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfdh_out_if;
    logic                valid;
    logic                ready;
    bfdh_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bfdh_front.sv -----
// ----------------------------------------------------------------------------
// Bloom filter hashing front
// Absorbs key bytes into two 64-bit hashes, one multiply pass per byte.
// ----------------------------------------------------------------------------
module bfdh_front (
    input  logic                clk,
    input  logic                rst_n,
    bfdh_in_if.sink             in_ch,
    output logic                job_valid,
    input  logic                job_ready,
    output bfdh_pkg::key_job_t  job
);
    import bfdh_pkg::*;

    // Each 64x64 low product is built from three 32x32 partial products,
    // one per cycle, with one multiplier for each hash.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] acc_a_reg, acc_a_next;
    logic [63:0] acc_b_reg, acc_b_next;
    logic [63:0] x_a_reg, x_a_next;
    logic [63:0] x_b_reg, x_b_next;
    logic [63:0] prod_a_reg, prod_a_next;
    logic [63:0] prod_b_reg, prod_b_next;
    logic [63:0] pa_reg, pb_reg;
    logic        last_reg, last_next;
    logic        op_reg, op_next;
    logic [31:0] opa_a, opb_a, opa_b, opb_b;
    logic [63:0] pp_a, pp_b;
    logic [63:0] ext;

    assign ext = {{56{in_ch.data.key_byte[7]}}, in_ch.data.key_byte};
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign job_valid   = (state_reg == ST_OUT);
    assign job.opcode  = op_reg;
    assign job.hash_a  = acc_a_reg;
    assign job.hash_b  = acc_b_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                opa_a = x_a_reg[31:0];  opb_a = MUL_A[31:0];
                opa_b = x_b_reg[31:0];  opb_b = MUL_B[31:0];
            end
            2'd1:
            begin
                opa_a = x_a_reg[63:32]; opb_a = MUL_A[31:0];
                opa_b = x_b_reg[63:32]; opb_b = MUL_B[31:0];
            end
            2'd2:
            begin
                opa_a = x_a_reg[31:0];  opb_a = MUL_A[63:32];
                opa_b = x_b_reg[31:0];  opb_b = MUL_B[63:32];
            end
            default:
            begin
                opa_a = 32'd0; opb_a = 32'd0;
                opa_b = 32'd0; opb_b = 32'd0;
            end
        endcase
        pp_a = 64'(opa_a) * 64'(opb_a);
        pp_b = 64'(opa_b) * 64'(opb_b);
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pp_a;
        pb_reg <= pp_b;
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;
        x_a_next    = x_a_reg;
        x_b_next    = x_b_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        last_next   = last_reg;
        op_next     = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    last_next = in_ch.data.last_byte;
                    op_next   = in_ch.data.opcode;
                    if (in_ch.data.has_byte)
                    begin
                        x_a_next    = acc_a_reg ^ ext;
                        x_b_next    = acc_b_reg ^ ext;
                        prod_a_next = 64'd0;
                        prod_b_next = 64'd0;
                        step_next   = 2'd0;
                        state_next  = ST_MUL;
                    end
                    else if (in_ch.data.last_byte)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL:
            begin
                step_next  = step_reg + 2'd1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                unique case (step_reg)
                    2'd1:
                    begin
                        prod_a_next = pa_reg;
                        prod_b_next = pb_reg;
                    end
                    default:
                    begin
                        prod_a_next = prod_a_reg + {pa_reg[31:0], 32'd0};
                        prod_b_next = prod_b_reg + {pb_reg[31:0], 32'd0};
                    end
                endcase
                if (step_reg == 2'd3)
                begin
                    acc_a_next = prod_a_reg + {pa_reg[31:0], 32'd0};
                    acc_b_next = prod_b_reg + {pb_reg[31:0], 32'd0};
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (job_ready)
                begin
                    acc_a_next = SEED_A;
                    acc_b_next = SEED_B;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            acc_a_reg <= SEED_A;
            acc_b_reg <= SEED_B;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_a_reg    <= x_a_next;
        x_b_reg    <= x_b_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        last_reg   <= last_next;
        op_reg     <= op_next;
    end

endmodule

// ----- design/bfdh_queue.sv -----
// ----------------------------------------------------------------------------
// Bloom filter job queue
// Two-entry queue of finished keys between the hashing and probing parts.
// ----------------------------------------------------------------------------
module bfdh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfdh_pkg::key_job_t  in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output bfdh_pkg::key_job_t  out_job
);
    import bfdh_pkg::*;

    key_job_t   mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/bfdh_back.sv -----
// ----------------------------------------------------------------------------
// Bloom filter probing back
// Reduces the hashes modulo N bit by bit, then probes or sets the bit store.
// ----------------------------------------------------------------------------
module bfdh_back #(
    parameter int unsigned MAX_BITS = bfdh_pkg::DEFAULT_MAX_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  bfdh_pkg::key_job_t             job,
    input  logic [bfdh_pkg::BITS_W-1:0]    active_bits,
    input  logic [bfdh_pkg::PROBE_W-1:0]   probe_count,
    bfdh_out_if.source                     out_ch
);
    import bfdh_pkg::*;

    localparam int unsigned AW = $clog2(MAX_BITS);
    localparam int unsigned NW = AW + 1;
    localparam int unsigned CW = (NW > BITS_W) ? NW : BITS_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic         mem [MAX_BITS];
    logic         rd_reg;
    logic [2:0]   state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [63:0]  sh_a_reg, sh_a_next;
    logic [63:0]  sh_b_reg, sh_b_next;
    logic [NW-1:0] r_a_reg, r_a_next;
    logic [NW-1:0] r_b_reg, r_b_next;
    logic [6:0]   bit_reg, bit_next;
    logic [NW-1:0] n_reg, n_next;
    logic [PROBE_W-1:0] k_reg, k_next;
    logic [PROBE_W-1:0] i_reg, i_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic         op_reg, op_next;
    logic         all_reg, all_next;
    logic         ov_reg, ov_next;
    logic         res_q_reg, res_q_next;
    logic         res_p_reg, res_p_next;
    logic [CW-1:0] n_sat;
    logic [PROBE_W-1:0] k_sat;
    logic [NW:0]  ta, tb, tn;
    logic         wr_en;

    always_comb
    begin
        n_sat = CW'(active_bits);
        if (n_sat < CW'(MIN_BITS))
            n_sat = CW'(MIN_BITS);
        else if (n_sat > CW'(MAX_BITS))
            n_sat = CW'(MAX_BITS);
        k_sat = probe_count;
        if (k_sat == '0)
            k_sat = PROBE_W'(1);
        else if (k_sat > PROBE_W'(MAX_PROBES))
            k_sat = PROBE_W'(MAX_PROBES);
    end

    // Restoring reduction: one hash bit per cycle per hash.
    assign ta = {r_a_reg, sh_a_reg[63]};
    assign tb = {r_b_reg, sh_b_reg[63]};
    assign tn = (NW+1)'(idx_reg) + (NW+1)'(r_b_reg);

    assign job_ready    = (state_reg == ST_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.data.was_query     = res_q_reg;
    assign out_ch.data.maybe_present = res_p_reg;
    assign wr_en = (state_reg == ST_CLEAR) ||
                   (state_reg == ST_READ && op_reg == OP_ADD);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[(state_reg == ST_CLEAR) ? clr_reg : idx_reg[AW-1:0]] <=
                (state_reg != ST_CLEAR);
        end
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        sh_a_next  = sh_a_reg;
        sh_b_next  = sh_b_reg;
        r_a_next   = r_a_reg;
        r_b_next   = r_b_reg;
        bit_next   = bit_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        all_next   = all_reg;
        ov_next    = ov_reg;
        res_q_next = res_q_reg;
        res_p_next = res_p_reg;
        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_BITS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    sh_a_next  = job.hash_a;
                    sh_b_next  = job.hash_b;
                    r_a_next   = '0;
                    r_b_next   = '0;
                    bit_next   = 7'd0;
                    n_next     = NW'(n_sat);
                    k_next     = k_sat;
                    op_next    = job.opcode;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                sh_a_next = {sh_a_reg[62:0], 1'b0};
                sh_b_next = {sh_b_reg[62:0], 1'b0};
                r_a_next  = (ta >= {1'b0, n_reg}) ? NW'(ta - {1'b0, n_reg}) : NW'(ta);
                r_b_next  = (tb >= {1'b0, n_reg}) ? NW'(tb - {1'b0, n_reg}) : NW'(tb);
                bit_next  = bit_reg + 7'd1;
                if (bit_reg == 7'd63)
                begin
                    idx_next   = r_a_next;
                    i_next     = '0;
                    all_next   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rd_reg)
                    all_next = 1'b0;
                idx_next = (tn >= {1'b0, n_reg}) ? NW'(tn - {1'b0, n_reg}) : NW'(tn);
                i_next   = i_reg + PROBE_W'(1);
                if (i_reg + PROBE_W'(1) == k_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    res_q_next = op_reg;
                    res_p_next = (op_reg == OP_QUERY) && all_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_a_reg  <= sh_a_next;
        sh_b_reg  <= sh_b_next;
        r_a_reg   <= r_a_next;
        r_b_reg   <= r_b_next;
        bit_reg   <= bit_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        idx_reg   <= idx_next;
        op_reg    <= op_next;
        all_reg   <= all_next;
        res_q_reg <= res_q_next;
        res_p_reg <= res_p_next;
    end

endmodule

// ----- design/bloom_filter_double_hash.sv -----
// Flow: each byte passes the front's multiply and sum states in its 32x32
// multipliers, and the front takes no new byte until it is absorbed. After
// the last byte of a key, the back reduces the hashes bit by bit, then reads
// or sets the bit store at each probe, overlapping the front via a two-entry queue.
// Reset: asynchronous, active low; afterwards the bit store is cleared, during
// which no key is probed (the front hashes until the queue fills).
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Top level: configuration registers, hashing front, queue, probing back.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
    parameter int unsigned MAX_BITS = bfdh_pkg::DEFAULT_MAX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]   cfg_data,
    bfdh_in_if.sink                           in_ch,
    bfdh_out_if.source                        out_ch
);
    import bfdh_pkg::*;

    logic [BITS_W-1:0]  bits_reg;
    logic [PROBE_W-1:0] probes_reg;
    logic               fj_valid, fj_ready, bj_valid, bj_ready;
    key_job_t           fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg   <= BITS_W'(65536);
            probes_reg <= PROBE_W'(7);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_BITS: bits_reg   <= cfg_data[BITS_W-1:0];
                REG_PROBE_COUNT: probes_reg <= cfg_data[PROBE_W-1:0];
                default: ;
            endcase
        end
    end

    bfdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    bfdh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_job    (fj),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_job   (bj)
    );

    bfdh_back #(.MAX_BITS(MAX_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (bj_valid),
        .job_ready   (bj_ready),
        .job         (bj),
        .active_bits (bits_reg),
        .probe_count (probes_reg),
        .out_ch      (out_ch)
    );

endmodule

// ----- tb/bloom_filter_double_hash_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter with double hashing: testbench
// A short directed table of keys is followed by random key sequences under
// several register settings and handshake idling patterns. Each result is
// checked against its row's typed values or an in-bench hash/store model.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_tb;
    import bfdh_pkg::*;

    typedef struct {
        logic       opcode;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last_byte;
        bit         typed;
        logic       exp_query;
        logic       exp_present;
    } stim_row_t;

    typedef struct {
        logic [7:0] bytes [8];
        int         len;
    } key_t;

    localparam int unsigned MAX_BITS_TB = DEFAULT_MAX_BITS;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bfdh_in_if  in_ch ();
    bfdh_out_if out_ch ();

    bloom_filter_double_hash i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    bit          filter_store [MAX_BITS_TB];
    logic [63:0] acc_a;
    logic [63:0] acc_b;
    logic [16:0] active_bits_reg;
    logic [4:0]  probe_count_reg;
    out_item_t   pending_results [$];
    key_t        added_keys [$];
    int          errors;
    int          idle_mode;

    logic [16:0] bits_set [6] = '{17'd64, 17'd65536, 17'd0, 17'd131071, 17'd1000, 17'd100};
    logic [16:0] probe_set [6] = '{17'd1, 17'd20, 17'd0, 17'd31, 17'd5, 17'd3};

    stim_row_t directed_rows [16] = '{
        '{OP_QUERY, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{OP_QUERY, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ADD,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_ADD,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_ADD,   8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ADD,   8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_ADD,   8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_ADD,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_QUERY, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_QUERY, 8'h55, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_QUERY, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic out_item_t filter_step(in_item_t item, output bit has_result);
        logic [63:0] ext;
        logic [63:0] n;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] idx;
        int          k;
        bit          all_set;
        out_item_t   res;
        has_result = 1'b0;
        res = '0;
        if (item.has_byte) begin
            ext = {{56{item.key_byte[7]}}, item.key_byte};
            acc_a = (acc_a ^ ext) * MUL_A;
            acc_b = (acc_b ^ ext) * MUL_B;
        end
        if (item.last_byte) begin
            n = active_bits_reg;
            if (n < MIN_BITS) n = MIN_BITS;
            if (n > MAX_BITS_TB) n = MAX_BITS_TB;
            k = probe_count_reg;
            if (k < 1) k = 1;
            if (k > MAX_PROBES) k = MAX_PROBES;
            h1 = acc_a % n;
            h2 = acc_b % n;
            all_set = 1'b1;
            for (int i = 0; i < k; i++) begin
                idx = (h1 + i * h2) % n;
                if (item.opcode == OP_ADD) filter_store[idx] = 1'b1;
                else if (!filter_store[idx]) all_set = 1'b0;
            end
            acc_a = SEED_A;
            acc_b = SEED_B;
            res.was_query = item.opcode;
            res.maybe_present = (item.opcode == OP_QUERY) && all_set;
            has_result = 1'b1;
        end
        return res;
    endfunction

    task automatic send_item(in_item_t item, bit typed, out_item_t typed_res);
        bit        has_result;
        out_item_t res;
        @(negedge clk);
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < ((idle_mode == 1) ? 87 : 14)) begin
                in_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        in_ch.valid = 1'b1;
        in_ch.data = item;
        do @(posedge clk); while (!in_ch.ready);
        res = filter_step(item, has_result);
        if (has_result) pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        in_ch.valid = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_ACTIVE_BITS) active_bits_reg = value;
        else probe_count_reg = value[4:0];
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_key(logic opcode);
        key_t      key;
        in_item_t  item;
        out_item_t none;
        none = '0;
        if (opcode == OP_QUERY && added_keys.size() != 0 && $urandom_range(1)) begin
            key = added_keys[$urandom_range(added_keys.size() - 1)];
        end else begin
            key.len = $urandom_range(7);
            for (int i = 0; i < 8; i++) key.bytes[i] = 8'($urandom_range(255));
        end
        if (opcode == OP_ADD) begin
            if (added_keys.size() > 40) void'(added_keys.pop_front());
            added_keys.push_back(key);
        end
        for (int i = 0; i < key.len; i++) begin
            if ($urandom_range(9) == 0) begin
                item = '{1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0};
                send_item(item, 1'b0, none);
            end
            item = '{1'($urandom_range(1)), key.bytes[i], 1'b1, 1'b0};
            if (i == key.len - 1) item.last_byte = 1'b1;
            if (i == key.len - 1) item.opcode = opcode;
            send_item(item, 1'b0, none);
        end
        if (key.len == 0) begin
            item = '{opcode, 8'($urandom_range(255)), 1'b0, 1'b1};
            send_item(item, 1'b0, none);
        end
    endtask

    always @(negedge clk) begin
        if (idle_mode == 2) out_ch.ready <= ($urandom_range(99) >= 87);
        else if (idle_mode == 3) out_ch.ready <= ($urandom_range(99) >= 14);
        else out_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_ch.data);
                errors++;
            end else begin
                if (out_ch.data.was_query !== pending_results[0].was_query) begin
                    $display("%0t: was_query expected %b actual %b", $time,
                             pending_results[0].was_query, out_ch.data.was_query);
                    errors++;
                end
                if (out_ch.data.maybe_present !== pending_results[0].maybe_present) begin
                    $display("%0t: maybe_present expected %b actual %b", $time,
                             pending_results[0].maybe_present, out_ch.data.maybe_present);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        in_item_t  item;
        out_item_t typed_res;
        errors = 0;
        idle_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ACTIVE_BITS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        acc_a = SEED_A;
        acc_b = SEED_B;
        active_bits_reg = 17'd65536;
        probe_count_reg = 5'd7;
        foreach (filter_store[i]) filter_store[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            item = '{directed_rows[r].opcode, directed_rows[r].key_byte,
                     directed_rows[r].has_byte, directed_rows[r].last_byte};
            typed_res = '{directed_rows[r].exp_query, directed_rows[r].exp_present};
            send_item(item, directed_rows[r].typed, typed_res);
        end
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_ACTIVE_BITS, bits_set[p]);
            write_reg(REG_PROBE_COUNT, probe_set[p]);
            idle_mode = p % 4;
            for (int k = 0; k < 28; k++) begin
                send_key((k % 3 == 0) ? OP_ADD : logic'($urandom_range(1)));
                if (p == 1 && k == 14) drain();
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
